// ===== hw/rtl/mam_pkg.sv =====
// Shared types, constants and codes for the modal assurance matrix block.
`default_nettype none

package mam_pkg;

   localparam int MODES_DEF  = 8;
   localparam int LENGTH_DEF = 256;

   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE_COUNT    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_LENGTH = 1'b1;

   localparam logic ACT_LOAD    = 1'b0;
   localparam logic ACT_COMPUTE = 1'b1;

   localparam logic [16:0] MAC_ONE = 17'h10000;

   typedef struct packed {
      logic               action;
      logic [2:0]         mode_index;
      logic [7:0]         element_index;
      logic signed [15:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]  row;
      logic [2:0]  column;
      logic [16:0] mac_value;
      logic        zero_norm;
      logic        last;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mam_ratio.sv =====
// Sequential unit: squares the dot magnitude, multiplies the norms, divides to Q1.16.
`default_nettype none

module mam_ratio
   import mam_pkg::*;
#(
   parameter int ACC_W = 40
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [ACC_W-1:0] mag,
   input  wire logic [ACC_W-1:0] norm_a,
   input  wire logic [ACC_W-1:0] norm_b,
   output logic                  done,
   output logic [16:0]           quot
);

   localparam int PW = 2 * ACC_W;
   localparam int CW = $clog2(ACC_W);

   typedef enum logic [3:0] {
      R_IDLE = 4'b0001,
      R_MUL1 = 4'b0010,
      R_MUL2 = 4'b0100,
      R_DIV  = 4'b1000
   } rstate_type;

   rstate_type       st_ff, st_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [PW-1:0]    prod_ff, prod_in;
   logic [PW-1:0]    mcand_ff, mcand_in;
   logic [ACC_W-1:0] mplier_ff, mplier_in;
   logic [ACC_W-1:0] na_ff, na_in;
   logic [ACC_W-1:0] nb_ff, nb_in;
   logic [PW-1:0]    den_ff, den_in;
   logic [PW:0]      rem_ff, rem_in;
   logic [16:0]      q_ff, q_in;
   logic             done_ff, done_in;

   logic [PW-1:0]    prod_step;
   logic [PW:0]      r_try;
   logic             r_ge;

   always_comb begin
      prod_step = mplier_ff[0] ? prod_ff + mcand_ff : prod_ff;
      r_try     = (cnt_ff == '0) ? rem_ff : {rem_ff[PW-1:0], 1'b0};
      r_ge      = r_try >= {1'b0, den_ff};

      st_in     = st_ff;
      cnt_in    = cnt_ff;
      prod_in   = prod_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      na_in     = na_ff;
      nb_in     = nb_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      done_in   = 1'b0;

      unique case (st_ff)
         R_IDLE: begin
            if (start) begin
               prod_in   = '0;
               mcand_in  = PW'(mag);
               mplier_in = mag;
               na_in     = norm_a;
               nb_in     = norm_b;
               cnt_in    = '0;
               st_in     = R_MUL1;
            end
         end
         R_MUL1: begin
            prod_in   = prod_step;
            mcand_in  = {mcand_ff[PW-2:0], 1'b0};
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CW'(ACC_W - 1)) begin
               rem_in    = {1'b0, prod_step};
               prod_in   = '0;
               mcand_in  = PW'(na_ff);
               mplier_in = nb_ff;
               cnt_in    = '0;
               st_in     = R_MUL2;
            end
         end
         R_MUL2: begin
            prod_in   = prod_step;
            mcand_in  = {mcand_ff[PW-2:0], 1'b0};
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CW'(ACC_W - 1)) begin
               den_in = prod_step;
               q_in   = '0;
               cnt_in = '0;
               st_in  = R_DIV;
            end
         end
         R_DIV: begin
            rem_in = r_ge ? r_try - {1'b0, den_ff} : r_try;
            q_in   = {q_ff[15:0], r_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(16)) begin
               done_in = 1'b1;
               st_in   = R_IDLE;
            end
         end
         default: st_in = R_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= R_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      prod_ff   <= prod_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      na_ff     <= na_in;
      nb_ff     <= nb_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      q_ff      <= q_in;
   end

   assign done = done_ff;
   assign quot = (q_ff > MAC_ONE) ? MAC_ONE : q_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/modal_assurance_matrix.sv =====
// Top level: vector memory, norm memory, entry sequencer and result register.
//
//   channel   ports                              handshake
//   request   start, busy, req_data              taken when start & !busy
//   result    rsp_valid, rsp_data                one-cycle strobe, no back-pressure
//   config    csr_we, csr_index, csr_wdata       write when csr_we
//
// A load item is written to the vector memory when it is taken. A compute item
// first walks every vector once for the norms, then each matrix entry: a diagonal
// or zero-norm entry is answered from the norm check alone, any other goes through
// the single vector-memory read stage, the accumulator and the bit-serial ratio unit.
// Reset is synchronous; the memories are not cleared. Results cannot be stalled.
`default_nettype none

module modal_assurance_matrix
   import mam_pkg::*;
#(
   parameter int MAX_MODES  = MODES_DEF,
   parameter int MAX_LENGTH = LENGTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   localparam int MW     = $clog2(MAX_MODES);
   localparam int LW     = $clog2(MAX_LENGTH);
   localparam int VDEPTH = MAX_MODES * MAX_LENGTH;
   localparam int AW     = $clog2(VDEPTH);
   localparam int ACC_W  = 32 + LW;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_NRUN   = 9'b000000010,
      S_NDRAIN = 9'b000000100,
      S_NSAVE  = 9'b000001000,
      S_NREAD  = 9'b000010000,
      S_NCHK   = 9'b000100000,
      S_DRUN   = 9'b001000000,
      S_DDRAIN = 9'b010000000,
      S_RATIO  = 9'b100000000
   } state_type;

   state_type               state_ff, state_in;
   logic [3:0]              mode_count_ff, mode_count_in;
   logic [8:0]              vector_length_ff, vector_length_in;
   logic [MW-1:0]           i_ff, i_in;
   logic [MW-1:0]           j_ff, j_in;
   logic [LW-1:0]           e_ff, e_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    v1_ff, v1_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [15:0]             vec_mem [VDEPTH];
   logic [15:0]             vec_qa_ff, vec_qb_ff;
   logic [ACC_W-1:0]        norm_mem [MAX_MODES];
   logic [ACC_W-1:0]        norm_qa_ff, norm_qb_ff;

   logic [MW:0]             modes_c;
   logic [LW:0]             len_c;
   logic                    accept, load_we, norm_we, issue, run;
   logic [AW-1:0]           load_addr, addr_a, addr_b;
   logic signed [31:0]      prod;
   logic [ACC_W-1:0]        mag;
   logic                    zn, diag, last_entry, j_end, ratio_start, ratio_done;
   logic [16:0]             ratio_q;

   assign accept  = start && (state_ff == S_IDLE);
   assign load_we = accept && (req_data.action == ACT_LOAD)
                    && (32'(req_data.mode_index) < MAX_MODES)
                    && (32'(req_data.element_index) < MAX_LENGTH);
   assign load_addr = AW'(32'(req_data.mode_index) * MAX_LENGTH
                          + 32'(req_data.element_index));

   assign modes_c = (32'(mode_count_ff) > MAX_MODES) ? (MW+1)'(MAX_MODES)
                                                     : (MW+1)'(mode_count_ff);
   assign len_c   = (32'(vector_length_ff) > MAX_LENGTH) ? (LW+1)'(MAX_LENGTH)
                                                         : (LW+1)'(vector_length_ff);

   assign run    = (state_ff == S_NRUN) || (state_ff == S_DRUN);
   assign issue  = run && (len_c != '0);
   assign addr_a = AW'(32'(i_ff) * MAX_LENGTH + 32'(e_ff));
   assign addr_b = AW'(32'((state_ff == S_NRUN) ? i_ff : j_ff) * MAX_LENGTH + 32'(e_ff));
   assign prod   = $signed(vec_qa_ff) * $signed(vec_qb_ff);
   assign mag    = (acc_ff < 0) ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign norm_we = (state_ff == S_NSAVE);

   assign zn         = (norm_qa_ff == '0) || (norm_qb_ff == '0);
   assign diag       = (i_ff == j_ff);
   assign j_end      = ((MW+1)'(j_ff) + 1'b1 == modes_c);
   assign last_entry = ((MW+1)'(i_ff) + 1'b1 == modes_c) && j_end;
   assign ratio_start = (state_ff == S_DDRAIN) && !v1_ff;

   always_ff @(posedge clock) begin
      if (load_we) begin
         vec_mem[load_addr] <= req_data.value;
      end
      vec_qa_ff <= vec_mem[addr_a];
      vec_qb_ff <= vec_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (norm_we) begin
         norm_mem[i_ff] <= ACC_W'(acc_ff);
      end
      norm_qa_ff <= norm_mem[i_ff];
      norm_qb_ff <= norm_mem[j_ff];
   end

   mam_ratio #(
      .ACC_W (ACC_W)
   ) u_ratio (
      .clock  (clock),
      .reset  (reset),
      .start  (ratio_start),
      .mag    (mag),
      .norm_a (norm_qa_ff),
      .norm_b (norm_qb_ff),
      .done   (ratio_done),
      .quot   (ratio_q)
   );

   always_comb begin
      state_in         = state_ff;
      mode_count_in    = mode_count_ff;
      vector_length_in = vector_length_ff;
      i_in             = i_ff;
      j_in             = j_ff;
      e_in             = e_ff;
      acc_in           = v1_ff ? acc_ff + ACC_W'(prod) : acc_ff;
      v1_in            = issue;
      rsp_valid_in     = 1'b0;
      rsp_in           = rsp_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE_COUNT:    mode_count_in    = csr_wdata[3:0];
            CSR_VECTOR_LENGTH: vector_length_in = csr_wdata;
            default: ;
         endcase
      end

      rsp_in.row       = 3'(i_ff);
      rsp_in.column    = 3'(j_ff);
      rsp_in.last      = last_entry;

      unique case (state_ff) inside
         S_IDLE: begin
            if (accept && (req_data.action == ACT_COMPUTE) && (modes_c != '0)) begin
               i_in     = '0;
               e_in     = '0;
               acc_in   = '0;
               state_in = S_NRUN;
            end
         end
         S_NRUN, S_DRUN: begin
            if (len_c == '0) begin
               state_in = (state_ff == S_NRUN) ? S_NDRAIN : S_DDRAIN;
            end else if ((LW+1)'(e_ff) + 1'b1 == len_c) begin
               e_in     = '0;
               state_in = (state_ff == S_NRUN) ? S_NDRAIN : S_DDRAIN;
            end else begin
               e_in = e_ff + 1'b1;
            end
         end
         S_NDRAIN: begin
            if (!v1_ff) begin
               state_in = S_NSAVE;
            end
         end
         S_NSAVE: begin
            acc_in = '0;
            if ((MW+1)'(i_ff) + 1'b1 == modes_c) begin
               i_in     = '0;
               j_in     = '0;
               state_in = S_NREAD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_NRUN;
            end
         end
         S_NREAD: begin
            state_in = S_NCHK;
         end
         S_NCHK: begin
            if (diag || zn) begin
               rsp_valid_in     = 1'b1;
               rsp_in.mac_value = diag ? MAC_ONE : '0;
               rsp_in.zero_norm = zn;
            end else begin
               acc_in   = '0;
               e_in     = '0;
               state_in = S_DRUN;
            end
         end
         S_DDRAIN: begin
            if (!v1_ff) begin
               state_in = S_RATIO;
            end
         end
         S_RATIO: begin
            if (ratio_done) begin
               rsp_valid_in     = 1'b1;
               rsp_in.mac_value = ratio_q;
               rsp_in.zero_norm = 1'b0;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (rsp_valid_in) begin
         if (last_entry) begin
            state_in = S_IDLE;
         end else begin
            state_in = S_NREAD;
            if (j_end) begin
               j_in = '0;
               i_in = i_ff + 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         mode_count_ff    <= 4'd8;
         vector_length_ff <= 9'd256;
         v1_ff            <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         acc_ff           <= '0;
      end else begin
         state_ff         <= state_in;
         mode_count_ff    <= mode_count_in;
         vector_length_ff <= vector_length_in;
         v1_ff            <= v1_in;
         rsp_valid_ff     <= rsp_valid_in;
         acc_ff           <= acc_in;
      end
      i_ff   <= i_in;
      j_ff   <= j_in;
      e_ff   <= e_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_diag_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.row == rsp_ff.column) |-> rsp_ff.mac_value == MAC_ONE)
      else $error("diagonal entry not 1.0");

   a_zero_norm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.zero_norm && (rsp_ff.row != rsp_ff.column)
      |-> rsp_ff.mac_value == '0)
      else $error("zero-norm entry not 0");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last |-> state_ff == S_IDLE)
      else $error("sequencer still running after last item");

   a_pipe_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RATIO |-> !v1_ff)
      else $error("accumulator pipe active during ratio");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for modal_assurance_matrix: directed and random load/compute items.
`default_nettype none

module tb_top;
   import mam_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   modal_assurance_matrix uut (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_we, .csr_index, .csr_wdata
   );

   always #10 clock = ~clock;

   logic signed [15:0] shape_mem [8][256];
   bit                 loaded [8][256];
   int unsigned        mode_count_q = 8;
   int unsigned        vector_len_q = 256;
   rsp_type            mac_expect_q [$];
   int                 error_count = 0;
   bit                 gaps_on = 1'b1;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic int unsigned used_modes();
      return mode_count_q > 8 ? 8 : mode_count_q;
   endfunction

   function automatic int unsigned used_len();
      return vector_len_q > 256 ? 256 : vector_len_q;
   endfunction

   // expected matrix entries for one compute item
   task automatic predict_matrix();
      int unsigned       modes;
      int unsigned       len;
      longint unsigned   norms [8];
      longint signed     dot;
      longint unsigned   mag;
      logic [127:0]      num;
      logic [127:0]      den;
      logic [127:0]      q;
      rsp_type           r;
      modes = used_modes();
      len = used_len();
      for (int i = 0; i < modes; i++) begin
         norms[i] = 0;
         for (int e = 0; e < len; e++)
            norms[i] += longint'(shape_mem[i][e]) * longint'(shape_mem[i][e]);
      end
      for (int i = 0; i < modes; i++) begin
         for (int j = 0; j < modes; j++) begin
            r.row = i[2:0];
            r.column = j[2:0];
            r.zero_norm = (norms[i] == 0) || (norms[j] == 0);
            r.last = (i == modes - 1) && (j == modes - 1);
            if (i == j) begin
               r.mac_value = MAC_ONE;
            end else if (r.zero_norm) begin
               r.mac_value = '0;
            end else begin
               dot = 0;
               for (int e = 0; e < len; e++)
                  dot += longint'(shape_mem[i][e]) * longint'(shape_mem[j][e]);
               mag = dot < 0 ? -dot : dot;
               num = {64'd0, mag} * {64'd0, mag};
               den = {64'd0, norms[i]} * {64'd0, norms[j]};
               q = (num << 16) / den;
               r.mac_value = q > 128'd65536 ? MAC_ONE : q[16:0];
            end
            mac_expect_q.insert(mac_expect_q.size(), r);
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid) begin
         if (mac_expect_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %p", rsp_data));
         end else begin
            exp_r = mac_expect_q.pop_front();
            if (rsp_data.row !== exp_r.row)
               report_mismatch($sformatf("row %0d exp %0d", rsp_data.row, exp_r.row));
            if (rsp_data.column !== exp_r.column)
               report_mismatch($sformatf("column %0d exp %0d",
                  rsp_data.column, exp_r.column));
            if (rsp_data.mac_value !== exp_r.mac_value)
               report_mismatch($sformatf("mac[%0d][%0d] %0d exp %0d", exp_r.row,
                  exp_r.column, rsp_data.mac_value, exp_r.mac_value));
            if (rsp_data.zero_norm !== exp_r.zero_norm)
               report_mismatch($sformatf("zero_norm %0b exp %0b",
                  rsp_data.zero_norm, exp_r.zero_norm));
            if (rsp_data.last !== exp_r.last)
               report_mismatch($sformatf("last %0b exp %0b", rsp_data.last, exp_r.last));
         end
      end
   end

   task automatic send_item(input req_type item);
      if (gaps_on && $urandom_range(99) < 9) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      if (item.action == ACT_LOAD) begin
         shape_mem[item.mode_index][item.element_index] = item.value;
         loaded[item.mode_index][item.element_index] = 1'b1;
      end else begin
         predict_matrix();
      end
   endtask

   task automatic load_element(input int m, input int e, input logic [15:0] v);
      req_type item;
      item.action = ACT_LOAD;
      item.mode_index = m[2:0];
      item.element_index = e[7:0];
      item.value = v;
      send_item(item);
   endtask

   // loads any element the compute would read but that was never written
   task automatic compute_matrix();
      req_type item;
      for (int m = 0; m < used_modes(); m++)
         for (int e = 0; e < used_len(); e++)
            if (!loaded[m][e]) load_element(m, e, 16'($urandom));
      item = '0;
      item.action = ACT_COMPUTE;
      item.mode_index = 3'($urandom);
      item.element_index = 8'($urandom);
      item.value = 16'($urandom);
      send_item(item);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (mac_expect_q.size() != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MODE_COUNT) mode_count_q = val & 4'hF;
      else vector_len_q = val & 9'h1FF;
      @(posedge clock);
   endtask

   task automatic set_shape(input int unsigned modes, input int unsigned len);
      write_csr(CSR_MODE_COUNT, modes);
      write_csr(CSR_VECTOR_LENGTH, len);
      @(posedge clock);
   endtask

   // extreme values, zero vector, parallel and opposite vectors
   task automatic test_directed_corners();
      set_shape(4, 4);
      for (int e = 0; e < 4; e++) begin
         load_element(0, e, e[0] ? 16'h7FFF : 16'h8000);
         load_element(1, e, e[0] ? 16'h8001 : 16'h7FFF);
         load_element(2, e, 16'h0000);
         load_element(3, e, e < 2 ? 16'h0001 : 16'hFFFF);
      end
      compute_matrix();
      drain();
   endtask

   // mode count zero, oversized mode count, length zero, oversized length
   task automatic test_register_limits();
      set_shape(0, 4);
      compute_matrix();
      drain();
      set_shape(15, 2);
      compute_matrix();
      drain();
      set_shape(5, 0);
      compute_matrix();
      drain();
      set_shape(1, 511);
      compute_matrix();
      drain();
      set_shape(8, 1);
      compute_matrix();
      drain();
   endtask

   task automatic test_random_phases(input int phases, input bit gaps);
      int unsigned modes;
      int unsigned len;
      gaps_on = gaps;
      for (int p = 0; p < phases; p++) begin
         modes = $urandom_range(1, 8);
         len = $urandom_range(0, 9) == 0 ? $urandom_range(16, 24) : $urandom_range(1, 12);
         set_shape(modes, len);
         for (int k = 0; k < 40; k++) begin
            if ($urandom_range(9) == 0)
               load_element($urandom_range(7), $urandom_range(255), 16'($urandom));
            else if ($urandom_range(4) == 0)
               load_element($urandom_range(modes - 1), $urandom_range(len - 1), 16'h0);
            else
               load_element($urandom_range(modes - 1), $urandom_range(len - 1),
                  16'($urandom));
            if ($urandom_range(14) == 0) compute_matrix();
         end
         compute_matrix();
         drain();
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_corners();
      test_register_limits();
      test_random_phases(1, 1'b0);
      test_random_phases(2, 1'b1);
      set_shape(8, 256);
      if (error_count == 0) begin
         $display("modal_assurance_matrix verification clean");
      end else begin
         $display("modal_assurance_matrix verification failed");
      end
      $finish;
   end

   initial begin
      #(60ms);
      $display("modal_assurance_matrix verification failed");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/mam_pkg.sv
hw/rtl/mam_ratio.sv
hw/rtl/modal_assurance_matrix.sv
verif/tb_top.sv
